// ----- sv/tgpr_pkg.sv -----
// shared types and constants for the toroidal gaussian place-cell rate block
`timescale 1ns / 1ps
package tgpr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DIST_THR    = 3'd2;
  localparam logic [2:0] REG_PEAK_RATE   = 3'd3;
  localparam logic [2:0] REG_GAUSS_SCALE = 3'd4;
  localparam logic [2:0] REG_ENABLE      = 3'd5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd32;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd32;
  localparam logic [15:0] RST_DIST_THR    = 16'd2560;
  localparam logic [15:0] RST_PEAK_RATE   = 16'd256;
  localparam logic [15:0] RST_GAUSS_SCALE = 16'd2048;
  localparam logic        RST_ENABLE      = 1'b1;

  // direction bias codes
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_LEFT  = 3'd4;

  // fixed-point constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;

  // squared distance range: wrapped components stay within -64..64
  localparam int D2W = 15;

  localparam int QDepth = 2;

  typedef struct packed {
    logic [6:0]  grid_width;
    logic [6:0]  grid_height;
    logic [15:0] distance_threshold;
    logic [15:0] peak_rate;
    logic [15:0] gauss_scale;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    logic [D2W-1:0] d2;
    logic [11:0]    cell_index;
  } q_entry_t;

  // handshake between front and queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

endpackage

// ----- sv/tgpr_front.sv -----
// front end: takes an item, applies the bias, wraps on the torus and squares
`timescale 1ns / 1ps
module tgpr_front import tgpr_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [5:0] cell_x_i,
  input  logic [5:0] cell_y_i,
  input  logic [5:0] pos_x_i,
  input  logic [5:0] pos_y_i,
  input  logic [2:0] direction_i,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       busy_o,
  output q_push_t    push_o
);

  // circumference registers are 7 bits, so a larger cap never bites
  localparam int DimCap = (MAX_DIM > 127) ? 127 : MAX_DIM;

  function automatic logic signed [8:0] wrap_axis(input logic signed [7:0] v,
                                                  input logic [6:0] circ);
    logic [6:0] dim;
    logic [7:0] mag8;
    logic [6:0] mag;
    logic [5:0] half;
    logic signed [8:0] res;
    dim  = (circ > 7'(DimCap)) ? 7'(DimCap) : circ;
    mag8 = v[7] ? 8'(-v) : 8'(v);
    mag  = mag8[6:0];
    half = dim[6:1];
    if ({1'b0, mag} >= {2'b0, half}) begin
      res = $signed({2'b0, dim}) - $signed({2'b0, mag});
    end else begin
      res = {v[7], v};
    end
    return res;
  endfunction

  logic              f_v_q, f_v_d;
  logic signed [8:0] dx_q, dy_q;
  logic [11:0]       cidx_q;
  logic              accept;
  logic              push;
  logic signed [7:0] dx_raw, dy_raw;
  logic signed [7:0] dx_b, dy_b;
  logic [12:0]       cidx_full;
  logic [17:0]       sq_x, sq_y;
  logic [D2W-1:0]    d2;

  assign busy_o = f_v_q && full_i;
  assign accept = start_i && !busy_o;
  assign push   = f_v_q && !full_i;

  always_comb begin
    dx_raw = $signed({2'b0, pos_x_i}) - $signed({2'b0, cell_x_i});
    dy_raw = $signed({2'b0, pos_y_i}) - $signed({2'b0, cell_y_i});
    dx_b   = dx_raw;
    dy_b   = dy_raw;
    // codes above left carry no bias
    case (direction_i)
      DIR_UP:    dy_b = dy_raw - 8'sd1;
      DIR_DOWN:  dy_b = dy_raw + 8'sd1;
      DIR_RIGHT: dx_b = dx_raw - 8'sd1;
      DIR_LEFT:  dx_b = dx_raw + 8'sd1;
      default:   ;
    endcase
    cidx_full = 13'(cell_y_i) * 13'(cfg_i.grid_width) + 13'(cell_x_i);
  end

  always_comb begin
    f_v_d = f_v_q;
    if (accept) begin
      f_v_d = 1'b1;
    end else if (push) begin
      f_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q   <= wrap_axis(dx_b, cfg_i.grid_width);
      dy_q   <= wrap_axis(dy_b, cfg_i.grid_height);
      cidx_q <= cidx_full[11:0];
    end
  end

  always_comb begin
    sq_x = 18'(dx_q) * 18'(dx_q);
    sq_y = 18'(dy_q) * 18'(dy_q);
    d2   = D2W'(sq_x) + D2W'(sq_y);
  end

  assign push_o.push             = push;
  assign push_o.entry.d2         = d2;
  assign push_o.entry.cell_index = cidx_q;

endmodule

// ----- sv/tgpr_queue.sv -----
// short queue between the front end and the rate pipeline
`timescale 1ns / 1ps
module tgpr_queue import tgpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_push_t  push_i,
  output logic     full_o,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  q_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  // back end never stalls, so whatever sits at the head leaves this cycle
  assign pop     = valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i.push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ----- sv/tgpr_back.sv -----
// back end: cutoff test, base-2 exponent split, table lookup and scaling
`timescale 1ns / 1ps
module tgpr_back import tgpr_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  q_entry_t    entry_i,
  input  cfg_t        cfg_i,
  output logic        done_o,
  output logic [15:0] rate_o,
  output logic [11:0] cell_index_o
);

  localparam int IdxW = $clog2(EXP_TABLE_DEPTH);
  localparam logic [IdxW:0] DepthV = (IdxW + 1)'(EXP_TABLE_DEPTH);

  // 2^(-i/depth) in Q16, from an integer taylor series in Q30
  logic [16:0] exp_tab [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] Z   = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    localparam logic [63:0] T1  = ((ONE_Q30 * Z) >> 30) / 1;
    localparam logic [63:0] T2  = ((T1 * Z) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * Z) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * Z) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * Z) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * Z) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * Z) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * Z) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * Z) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * Z) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * Z) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * Z) >> 30) / 12;
    localparam logic [63:0] T13 = ((T12 * Z) >> 30) / 13;
    localparam logic [63:0] T14 = ((T13 * Z) >> 30) / 14;
    localparam logic [63:0] T15 = ((T14 * Z) >> 30) / 15;
    localparam logic [63:0] T16 = ((T15 * Z) >> 30) / 16;
    localparam logic [63:0] T17 = ((T16 * Z) >> 30) / 17;
    localparam logic [63:0] T18 = ((T17 * Z) >> 30) / 18;
    localparam logic [63:0] T19 = ((T18 * Z) >> 30) / 19;
    localparam logic [63:0] Pos = ONE_Q30 + T2 + T4 + T6 + T8 + T10 + T12 + T14
                                  + T16 + T18;
    localparam logic [63:0] Neg = T1 + T3 + T5 + T7 + T9 + T11 + T13 + T15
                                  + T17 + T19;
    localparam logic [63:0] Ent = (Pos - Neg + 64'd8192) >> 14;
    assign exp_tab[i] = Ent[16:0];
  end

  // stage valids
  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, out_v_q;

  logic [31:0]  thr2_q;
  // stage 1
  logic [30:0]  x_q;
  logic         hit1_q;
  logic [11:0]  cidx1_q;
  // stage 2
  logic [15:0]  n_q, f_q;
  logic         hit2_q;
  logic [11:0]  cidx2_q;
  // stage 3
  logic [16:0]  ent_q;
  logic [5:0]   sh3_q;
  logic         zero3_q;
  logic [11:0]  cidx3_q;
  // stage 4
  logic [32:0]  prod_q;
  logic [5:0]   sh4_q;
  logic         zero4_q;
  logic [11:0]  cidx4_q;
  // output
  logic [15:0]  rate_q;
  logic [11:0]  cidx_out_q;

  logic              hit1;
  logic [47:0]       y_full;
  logic [16+IdxW:0]  idx_full;
  logic [IdxW-1:0]   idx;
  logic [32:0]       shifted;

  assign hit1     = cfg_i.enable && ({1'b0, entry_i.d2, 16'h0} < thr2_q);
  assign y_full   = 48'(x_q) * 48'(LOG2E_Q16);
  assign idx_full = (17 + IdxW)'(f_q) * (17 + IdxW)'(DepthV);
  assign idx      = idx_full[16 +: IdxW];
  assign shifted  = prod_q >> sh4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      b1_v_q  <= valid_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      out_v_q <= b4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    thr2_q <= cfg_i.distance_threshold * cfg_i.distance_threshold;

    x_q     <= 31'(entry_i.d2) * 31'(cfg_i.gauss_scale);
    hit1_q  <= hit1;
    cidx1_q <= entry_i.cell_index;

    n_q     <= y_full[47:32];
    f_q     <= y_full[31:16];
    hit2_q  <= hit1_q;
    cidx2_q <= cidx1_q;

    ent_q   <= exp_tab[idx];
    // a shift of 33 or more clears the 33-bit product
    zero3_q <= !hit2_q || (n_q >= 16'd17);
    sh3_q   <= 6'd16 + 6'(n_q[4:0]);
    cidx3_q <= cidx2_q;

    prod_q  <= 33'(cfg_i.peak_rate) * 33'(ent_q);
    sh4_q   <= sh3_q;
    zero4_q <= zero3_q;
    cidx4_q <= cidx3_q;

    rate_q     <= zero4_q ? 16'h0 : shifted[15:0];
    cidx_out_q <= cidx4_q;
  end

  assign done_o       = out_v_q;
  assign rate_o       = rate_q;
  assign cell_index_o = cidx_out_q;

endmodule

// ----- sv/toroidal_gaussian_place_rate.sv -----
// top level: configuration registers, front end, queue and rate pipeline
`timescale 1ns / 1ps
// Computes the gaussian firing rate of one place cell on a torus per item.
// A new item may be started every clock cycle while busy_o is low; its result
// appears on the result ports, marked by done_o, for one cycle after passing
// the wrap/square front end register, the queue and the rate pipeline
// stages (cutoff and scale multiply, log2(e) multiply, exp table lookup,
// amplitude multiply, output shift). The receiver cannot hold results off,
// and busy_o stays low in normal use because the rate pipeline drains the
// queue every cycle. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must do so only while no item is in flight, which the
// block itself does not enforce.
module toroidal_gaussian_place_rate import tgpr_pkg::*; #(
  parameter int MAX_DIM         = 64,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [5:0]          cell_x_i,
  input  logic [5:0]          cell_y_i,
  input  logic [5:0]          pos_x_i,
  input  logic [5:0]          pos_y_i,
  input  logic [2:0]          direction_i,
  output logic                done_o,
  output logic [15:0]         rate_o,
  output logic [11:0]         cell_index_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  q_push_t  q_push;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width         <= RST_GRID_WIDTH;
      cfg_q.grid_height        <= RST_GRID_HEIGHT;
      cfg_q.distance_threshold <= RST_DIST_THR;
      cfg_q.peak_rate          <= RST_PEAK_RATE;
      cfg_q.gauss_scale        <= RST_GAUSS_SCALE;
      cfg_q.enable             <= RST_ENABLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  cfg_q.grid_width         <= cfg_data_i[6:0];
        REG_GRID_HEIGHT: cfg_q.grid_height        <= cfg_data_i[6:0];
        REG_DIST_THR:    cfg_q.distance_threshold <= cfg_data_i;
        REG_PEAK_RATE:   cfg_q.peak_rate          <= cfg_data_i;
        REG_GAUSS_SCALE: cfg_q.gauss_scale        <= cfg_data_i;
        REG_ENABLE:      cfg_q.enable             <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  tgpr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .direction_i (direction_i),
    .cfg_i       (cfg_q),
    .full_i      (q_full),
    .busy_o      (busy_o),
    .push_o      (q_push)
  );

  tgpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  tgpr_back #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .entry_i      (q_entry),
    .cfg_i        (cfg_q),
    .done_o       (done_o),
    .rate_o       (rate_o),
    .cell_index_o (cell_index_o)
  );

endmodule

// ----- sv/tgpr_checker.sv -----
// port-level assertions for the place-rate block, bound to the top level
`timescale 1ns / 1ps
module tgpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [5:0]  cell_x_i,
  input logic [5:0]  cell_y_i,
  input logic        done_o,
  input logic [11:0] cell_index_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  // every started item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##7 done_o)
    else $error("result missing after the fixed latency");

  // no result without a matching start
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc && rst_ni, 7))
    else $error("result without a started item");

  // the queue is always drained, so the front end never blocks
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy raised although the pipeline never stalls");

  // on row zero the linear index is just the x coordinate
  a_row_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cell_y_i == 6'd0) |-> ##7 (cell_index_o == 12'($past(cell_x_i, 7))))
    else $error("cell index wrong for a cell on row zero");

endmodule

bind toroidal_gaussian_place_rate tgpr_checker u_tgpr_checker (.*);

// ----- tb/tb_toroidal_gaussian_place_rate.sv -----
// self-checking testbench for the toroidal gaussian place-cell rate block
`timescale 1ns / 1ps
module tb_toroidal_gaussian_place_rate;
  import tgpr_pkg::*;

  localparam int MAX_DIM   = 64;
  localparam int EXP_DEPTH = 256;

  // register indexes with no register behind them
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // direction codes outside the defined set
  localparam logic [2:0] DIR_UNUSED_LO  = 3'd5;
  localparam logic [2:0] DIR_UNUSED_MID = 3'd6;
  localparam logic [2:0] DIR_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [15:0] rate;
    logic [11:0] cell_index;
  } rate_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic [5:0]          cell_x_i     = '0;
  logic [5:0]          cell_y_i     = '0;
  logic [5:0]          pos_x_i      = '0;
  logic [5:0]          pos_y_i      = '0;
  logic [2:0]          direction_i  = DIR_NONE;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = REG_GRID_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                busy_o;
  logic                done_o;
  logic [15:0]         rate_o;
  logic [11:0]         cell_index_o;

  cfg_t         grid_cfg;
  logic [31:0]  exp_q16 [EXP_DEPTH];
  rate_result_t rate_due_q [$];
  int           idle_pct = 34;
  int           mismatch_count = 0;
  int           results_checked = 0;
  int           live_rates = 0;
  int           items_sent = 0;
  int           settings_loaded = 0;

  toroidal_gaussian_place_rate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .direction_i (direction_i),
    .done_o      (done_o),
    .rate_o      (rate_o),
    .cell_index_o(cell_index_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // 2^(-i/depth) in Q16 from a Taylor series of exp(-i*ln2/depth) in Q30
  function automatic logic [31:0] pow2_neg_q16(input int i);
    longint unsigned z, term, pos, neg;
    int k;
    z = (64'(i) * LN2_Q30) / EXP_DEPTH;
    term = ONE_Q30;
    pos = ONE_Q30;
    neg = 0;
    for (k = 1; k < 20; k++) begin
      term = (term * z) >> 30;
      term = term / k;
      if (k & 1) neg += term;
      else pos += term;
    end
    return 32'(((pos - neg) + (64'd1 << 13)) >> 14);
  endfunction

  function automatic int wrap_on_torus(input int v, input logic [6:0] circ);
    int dim, half, mag;
    dim = (circ > MAX_DIM) ? MAX_DIM : int'(circ);
    half = dim / 2;
    mag = (v < 0) ? -v : v;
    return (mag >= half) ? dim - mag : v;
  endfunction

  function automatic rate_result_t place_rate_of(input logic [5:0] cx, input logic [5:0] cy,
                                                 input logic [5:0] px, input logic [5:0] py,
                                                 input logic [2:0] dir);
    int dx, dy, idx;
    longint unsigned d2, thr2, x, y, n, f, prod, sh;
    rate_result_t r;
    dx = int'(px) - int'(cx);
    dy = int'(py) - int'(cy);
    case (dir)
      DIR_UP:    dy -= 1;
      DIR_DOWN:  dy += 1;
      DIR_RIGHT: dx -= 1;
      DIR_LEFT:  dx += 1;
      default:   ;
    endcase
    dx = wrap_on_torus(dx, grid_cfg.grid_width);
    dy = wrap_on_torus(dy, grid_cfg.grid_height);
    d2 = 64'(dx * dx + dy * dy);
    thr2 = 64'(grid_cfg.distance_threshold) * 64'(grid_cfg.distance_threshold);
    r.rate = '0;
    if (grid_cfg.enable && (d2 << 16) < thr2) begin
      x = d2 * 64'(grid_cfg.gauss_scale);
      y = (x * 64'(LOG2E_Q16)) >> 16;
      n = y >> 16;
      f = y & 64'hFFFF;
      idx = int'((f * EXP_DEPTH) >> 16) % EXP_DEPTH;
      prod = 64'(grid_cfg.peak_rate) * 64'(exp_q16[idx]);
      sh = 64'd16 + n;
      r.rate = (sh >= 64) ? 16'd0 : 16'(prod >> sh);
    end
    r.cell_index = 12'(64'(cy) * 64'(grid_cfg.grid_width) + 64'(cx));
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // leaves the write enable high so back-to-back writes need no toggle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_GRID_WIDTH:  grid_cfg.grid_width = data[6:0];
      REG_GRID_HEIGHT: grid_cfg.grid_height = data[6:0];
      REG_DIST_THR:    grid_cfg.distance_threshold = data;
      REG_PEAK_RATE:   grid_cfg.peak_rate = data;
      REG_GAUSS_SCALE: grid_cfg.gauss_scale = data;
      REG_ENABLE:      grid_cfg.enable = data[0];
      default:         ;
    endcase
  endtask

  // unused upper data bits carry junk to check the register masking
  task automatic load_cfg(input cfg_t c);
    write_reg(REG_GRID_WIDTH, {9'($urandom), c.grid_width});
    write_reg(REG_GRID_HEIGHT, {9'($urandom), c.grid_height});
    write_reg(REG_DIST_THR, c.distance_threshold);
    write_reg(REG_PEAK_RATE, c.peak_rate);
    write_reg(REG_GAUSS_SCALE, c.gauss_scale);
    write_reg(REG_ENABLE, {15'($urandom), c.enable});
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_cell(input logic [5:0] cx, input logic [5:0] cy,
                           input logic [5:0] px, input logic [5:0] py,
                           input logic [2:0] dir);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cell_x_i    <= cx;
    cell_y_i    <= cy;
    pos_x_i     <= px;
    pos_y_i     <= py;
    direction_i <= dir;
    // the item is taken at the first edge that sees busy low
    @(posedge clk_i iff !busy_o);
    rate_due_q.push_back(place_rate_of(cx, cy, px, py, dir));
    items_sent++;
  endtask

  // hold off until every pending result is back, then let the pipe go quiet
  task automatic settle_pipeline();
    start_i <= 1'b0;
    while (rate_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rate_result_t want;
    if (rst_ni && done_o) begin
      if (rate_due_q.size() == 0) begin
        flag_mismatch("result with no item pending, rate", 0, rate_o);
      end else begin
        want = rate_due_q.pop_front();
        if (rate_o !== want.rate) flag_mismatch("rate", want.rate, rate_o);
        if (cell_index_o !== want.cell_index)
          flag_mismatch("cell_index", want.cell_index, cell_index_o);
        results_checked++;
        if (want.rate != 0) live_rates++;
      end
    end
  end

  task automatic test_reset_defaults();
    send_cell(6'd0, 6'd0, 6'd0, 6'd0, DIR_NONE);
    send_cell(6'd63, 6'd63, 6'd63, 6'd63, DIR_NONE);
    send_cell(6'd0, 6'd0, 6'd63, 6'd63, DIR_NONE);
    send_cell(6'd10, 6'd20, 6'd13, 6'd24, DIR_NONE);
    send_cell(6'd10, 6'd20, 6'd10, 6'd20, DIR_UP);
    send_cell(6'd10, 6'd20, 6'd10, 6'd20, DIR_DOWN);
    send_cell(6'd10, 6'd20, 6'd10, 6'd20, DIR_RIGHT);
    send_cell(6'd10, 6'd20, 6'd10, 6'd20, DIR_LEFT);
    send_cell(6'd10, 6'd20, 6'd12, 6'd21, DIR_UNUSED_LO);
    send_cell(6'd10, 6'd20, 6'd12, 6'd21, DIR_UNUSED_MID);
    send_cell(6'd10, 6'd20, 6'd12, 6'd21, DIR_UNUSED_HI);
    send_cell(6'd31, 6'd0, 6'd0, 6'd47, DIR_NONE);
    settle_pipeline();
  endtask

  task automatic test_grid_extremes();
    cfg_t c;
    c = '{grid_width: 7'd0, grid_height: 7'd1, distance_threshold: 16'hFFFF,
          peak_rate: 16'd256, gauss_scale: 16'd2048, enable: 1'b1};
    load_cfg(c);
    send_cell(6'd5, 6'd9, 6'd12, 6'd3, DIR_LEFT);
    send_cell(6'd0, 6'd0, 6'd0, 6'd0, DIR_NONE);
    settle_pipeline();
    c.grid_width = 7'd127;
    c.grid_height = 7'd100;
    load_cfg(c);
    send_cell(6'd0, 6'd0, 6'd63, 6'd40, DIR_DOWN);
    send_cell(6'd63, 6'd63, 6'd0, 6'd0, DIR_RIGHT);
    settle_pipeline();
    c.grid_width = 7'd2;
    c.grid_height = 7'd2;
    load_cfg(c);
    send_cell(6'd0, 6'd1, 6'd1, 6'd0, DIR_UP);
    settle_pipeline();
  endtask

  task automatic test_cutoff_and_disable();
    cfg_t c;
    c = '{grid_width: 7'd64, grid_height: 7'd64, distance_threshold: 16'd0,
          peak_rate: 16'd256, gauss_scale: 16'd2048, enable: 1'b1};
    load_cfg(c);
    send_cell(6'd7, 6'd7, 6'd7, 6'd7, DIR_NONE);
    settle_pipeline();
    c.distance_threshold = 16'd2560;
    c.enable = 1'b0;
    load_cfg(c);
    send_cell(6'd7, 6'd7, 6'd7, 6'd7, DIR_NONE);
    settle_pipeline();
  endtask

  task automatic test_amplitude_extremes();
    cfg_t c;
    c = '{grid_width: 7'd64, grid_height: 7'd64, distance_threshold: 16'd2560,
          peak_rate: 16'hFFFF, gauss_scale: 16'd0, enable: 1'b1};
    load_cfg(c);
    send_cell(6'd0, 6'd0, 6'd3, 6'd4, DIR_NONE);
    send_cell(6'd40, 6'd40, 6'd40, 6'd40, DIR_NONE);
    settle_pipeline();
    c.gauss_scale = 16'hFFFF;
    c.peak_rate = 16'd0;
    load_cfg(c);
    send_cell(6'd0, 6'd0, 6'd1, 6'd0, DIR_NONE);
    settle_pipeline();
    c.peak_rate = 16'hFFFF;
    load_cfg(c);
    send_cell(6'd0, 6'd0, 6'd1, 6'd0, DIR_NONE);
    settle_pipeline();
  endtask

  task automatic test_unused_reg_index();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    cfg_we_i <= 1'b0;
    send_cell(6'd20, 6'd30, 6'd21, 6'd30, DIR_NONE);
    settle_pipeline();
  endtask

  // mostly legal sizes, sometimes degenerate or oversized
  function automatic logic [6:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 7'($urandom_range(1));
    if (r < 16) return 7'($urandom_range(127, 65));
    return 7'($urandom_range(64, 2));
  endfunction

  task automatic test_random_sweep();
    cfg_t c;
    int phase, k, ox, oy;
    logic [5:0] cx, cy;
    for (phase = 0; phase < 8; phase++) begin
      c.grid_width = pick_dim();
      c.grid_height = pick_dim();
      c.distance_threshold = ($urandom_range(9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(4096, 256));
      c.peak_rate = 16'($urandom);
      c.gauss_scale = ($urandom_range(6) == 0) ? 16'($urandom) : 16'($urandom_range(4096));
      c.enable = ($urandom_range(9) != 0);
      load_cfg(c);
      // one phase runs back to back with no gaps at all
      idle_pct = (phase == 3) ? 0 : 34;
      for (k = 0; k < 220; k++) begin
        cx = 6'($urandom);
        cy = 6'($urandom);
        if ($urandom_range(99) < 70) begin
          // position near the cell so the cutoff is passed often
          ox = int'($urandom_range(24)) - 12;
          oy = int'($urandom_range(24)) - 12;
          send_cell(cx, cy, 6'(int'(cx) + ox), 6'(int'(cy) + oy), 3'($urandom));
        end else begin
          send_cell(cx, cy, 6'($urandom), 6'($urandom), 3'($urandom));
        end
      end
      settle_pipeline();
    end
    idle_pct = 34;
  endtask

  initial begin
    int w;
    grid_cfg = '{grid_width: RST_GRID_WIDTH, grid_height: RST_GRID_HEIGHT,
                 distance_threshold: RST_DIST_THR, peak_rate: RST_PEAK_RATE,
                 gauss_scale: RST_GAUSS_SCALE, enable: RST_ENABLE};
    for (w = 0; w < EXP_DEPTH; w++) exp_q16[w] = pow2_neg_q16(w);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_grid_extremes();
    test_cutoff_and_disable();
    test_amplitude_extremes();
    test_unused_reg_index();
    test_random_sweep();

    start_i <= 1'b0;
    for (w = 0; w < 200 && rate_due_q.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (rate_due_q.size() != 0)
      flag_mismatch("results never arrived", 0, rate_due_q.size());

    $display("%0d items sent under %0d register settings, %0d results checked",
             items_sent, settings_loaded + 1, results_checked);
    $display("%0d results carried a nonzero rate, %0d mismatches", live_rates,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", rate_due_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
